FILE: rtl/core/ilir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants for the positional insert/remove list.
// ----------------------------------------------------------------------------
package ilir_pkg;

  // Fixed field widths of the stream items
  localparam int POS_W    = 5;
  localparam int ELEM_W   = 32;
  localparam int DOUT_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int FUNC_W   = 2;

  // Packed stream widths (rounded up to whole bytes)
  localparam int IN_TDATA_W  = 40;  // position + element + pad
  localparam int OUT_TDATA_W = 40;  // data + status + count + empty_res

  // Parameter defaults
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic             shift_up;    // legal insert
    logic             shift_down;  // legal remove
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/indexed_list_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Bounded positional list built from a row of shifting cells.
//
//  port group | dir | contents
//  -----------+-----+---------------------------------------------------------
//  in_        | in  | tuser: func; tdata: position, element
//  out_       | out | tdata: data, status, count, empty_res
//
// All cells shift together, so the result of an accepted item is registered
// and shows in the cycle after its acceptance, and a new item can enter each
// cycle while the result register drains.
// The result register stalls the input side only while a result waits and
// out_tready is low. Reset empties the list (count zero); entries need no
// clearing since only written slots are ever read.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
  parameter int CAPACITY   = ilir_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ilir_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ilir_pkg::IN_TDATA_W-1:0]   in_tdata,   // [4:0] position, [36:5] element
  input  logic [ilir_pkg::FUNC_W-1:0]       in_tuser,   // [1:0] func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ilir_pkg::OUT_TDATA_W-1:0]  out_tdata   // [31:0] data, [33:32] status,
                                                        // [38:34] count, [39] empty_res
);
  import ilir_pkg::*;

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

  // Unpacked input item
  op_t                   func;
  logic [POS_W-1:0]      position;
  logic [ELEM_W-1:0]     element;
  logic [DATA_WIDTH-1:0] elem_w;
  logic                  accept;

  // List state
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  fill_c;
  logic              full;

  // Cell row
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] cell_q   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;

  // Result
  status_t           status_c;
  logic [DOUT_W-1:0] data_c;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DOUT_W-1:0] out_data_r;
  status_t           out_status_r;
  logic [COUNT_W-1:0] out_count_r;
  logic              out_empty_r;

  assign func     = op_t'(in_tuser);
  assign position = in_tdata[POS_W-1:0];
  assign element  = in_tdata[POS_W +: ELEM_W];
  assign elem_w   = DATA_WIDTH'(element);

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign pos_c  = CMP_W'(position);
  assign fill_c = CMP_W'(fill_r);
  assign full   = (fill_r == FILL_W'(CAPACITY));

  // Gather the addressed entry from the cell taps
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_tap[i];
    end
  end

  // Decode the command and check the position
  always_comb begin
    ctrl            = '0;
    ctrl.pos        = position;
    status_c        = ST_OK;
    data_c          = '0;
    fill_nxt        = fill_r;
    case (func)
      OP_INSERT: begin
        if (pos_c > fill_c) begin
          status_c = ST_BADPOS;
        end else if (full) begin
          status_c = ST_FULL;
        end else begin
          ctrl.shift_up = accept;
          fill_nxt      = fill_r + FILL_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_c >= fill_c) begin
          status_c = ST_BADPOS;
        end else begin
          ctrl.shift_down = accept;
          data_c          = DOUT_W'(rd_data);
          fill_nxt        = fill_r - FILL_W'(1);
        end
      end
      OP_GET: begin
        if (pos_c >= fill_c) begin
          status_c = ST_BADPOS;
        end else begin
          data_c = DOUT_W'(rd_data);
        end
      end
      OP_CLEAR: begin
        fill_nxt = '0;
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  // Row of cells, each wired to its two neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_q;
    logic [DATA_WIDTH-1:0] upper_q;

    if (g == 0) begin : g_first
      assign lower_q = '0;
    end else begin : g_mid_lo
      assign lower_q = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign upper_q = '0;
    end else begin : g_mid_hi
      assign upper_q = cell_q[g+1];
    end

    ilir_cell #(
      .INDEX      (g),
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .elem    (elem_w),
      .lower_q (lower_q),
      .upper_q (upper_q),
      .q       (cell_q[g]),
      .rd_tap  (cell_tap[g])
    );
  end

  // Drop the result flag once taken, set it on a new item
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold the count and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= data_c;
      out_status_r <= status_c;
      out_count_r  <= COUNT_W'(fill_nxt);
      out_empty_r  <= (fill_nxt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_empty_r, out_count_r, out_status_r, out_data_r};

endmodule

FILE: rtl/core/ilir_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot: holds an entry, takes its lower or upper neighbor on a
// shift, loads the new element at the insert position and offers its entry
// on the read tap when it sits at the addressed position.
// ----------------------------------------------------------------------------
module ilir_cell #(
  parameter int INDEX      = 0,
  parameter int CAPACITY   = ilir_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ilir_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  ilir_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0]  elem,
  input  logic [DATA_WIDTH-1:0]  lower_q,   // entry of the cell one place down
  input  logic [DATA_WIDTH-1:0]  upper_q,   // entry of the cell one place up
  output logic [DATA_WIDTH-1:0]  q,
  output logic [DATA_WIDTH-1:0]  rd_tap
);
  import ilir_pkg::*;

  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IDX_W    = (IDX_BITS > POS_W) ? IDX_BITS : POS_W;

  logic [IDX_W-1:0]      my_idx;
  logic [IDX_W-1:0]      pos_c;
  logic                  at_pos;
  logic                  above_pos;
  logic [DATA_WIDTH-1:0] q_r;
  logic [DATA_WIDTH-1:0] q_nxt;

  assign my_idx    = IDX_W'(INDEX);
  assign pos_c     = IDX_W'(ctrl.pos);
  assign at_pos    = (my_idx == pos_c);
  assign above_pos = (my_idx > pos_c);

  // Pick the next entry: open a gap on insert, close it on remove
  always_comb begin
    q_nxt = q_r;
    if (ctrl.shift_up) begin
      if (at_pos) begin
        q_nxt = elem;
      end else if (above_pos) begin
        q_nxt = lower_q;
      end
    end else if (ctrl.shift_down) begin
      if (at_pos || above_pos) begin
        q_nxt = upper_q;
      end
    end
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q      = q_r;
  assign rd_tap = at_pos ? q_r : '0;

endmodule

FILE: test/tb_indexed_list_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove
// Self-checking bench for the positional insert/remove list. A directed table
// walks the empty, full and out-of-range cases. Random command streams follow,
// mostly legal positions with some out-of-range and clear items mixed in.
// Every accepted item runs through a local list model. Each result leaving
// the block is compared field by field with the oldest prediction. Both
// stream sides idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_remove;
  import ilir_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int TAIL_ITEMS   = 60;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [DOUT_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } list_result_t;

  typedef struct {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] elem;
    bit                typed;    // result below is written out by hand
    list_result_t      res;
  } list_cmd_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // [4:0] position, [36:5] element
  logic [FUNC_W-1:0]      in_tuser   = '0;  // [1:0] func
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [31:0] data, [33:32] status,
                                            // [38:34] count, [39] empty_res

  // Model of the list contents
  logic [ELEM_W-1:0] list_mem [LIST_DEPTH];
  int                model_fill = 0;

  list_result_t pending_q [$];
  list_cmd_t    directed_cmds [$];
  int           err_cnt    = 0;
  int           cycle_cnt  = 0;
  int           stall_left = 0;
  logic         quiet_tail = 1'b0;

  indexed_list_insert_remove dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Apply one command to the model list and return its result
  task automatic apply_list_cmd(input op_t op, input logic [POS_W-1:0] pos,
                                input logic [ELEM_W-1:0] elem,
                                output list_result_t r);
    int i;
    r.data   = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (pos > model_fill) begin
          r.status = ST_BADPOS;
        end else if (model_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = model_fill; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = elem;
          model_fill++;
        end
      end
      OP_REMOVE: begin
        if (pos >= model_fill) begin
          r.status = ST_BADPOS;
        end else begin
          r.data = list_mem[pos];
          for (i = pos; i + 1 < model_fill; i++) list_mem[i] = list_mem[i+1];
          model_fill--;
        end
      end
      OP_GET: begin
        if (pos >= model_fill) r.status = ST_BADPOS;
        else r.data = list_mem[pos];
      end
      default: begin
        model_fill = 0;
      end
    endcase
    r.count     = model_fill[COUNT_W-1:0];
    r.empty_res = (model_fill == 0);
  endtask

  task automatic add_cmd(input op_t op, input int pos, input logic [ELEM_W-1:0] elem,
                         input bit typed, input logic [DOUT_W-1:0] data,
                         input status_t st, input int cnt);
    list_cmd_t c;
    c.op            = op;
    c.pos           = pos[POS_W-1:0];
    c.elem          = elem;
    c.typed         = typed;
    c.res.data      = data;
    c.res.status    = st;
    c.res.count     = cnt[COUNT_W-1:0];
    c.res.empty_res = (cnt == 0);
    directed_cmds.push_back(c);
  endtask

  // Present one item, hold it until accepted, then record its prediction
  task automatic send_cmd(input list_cmd_t c);
    list_result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= c.op;
    in_tdata  <= {{(IN_TDATA_W-ELEM_W-POS_W){1'b0}}, c.elem, c.pos};
    do @(posedge clk); while (!in_tready);
    apply_list_cmd(c.op, c.pos, c.elem, r);
    if (c.typed) r = c.res;
    pending_q.push_back(r);
  endtask

  // Drop valid for a random burst now and then
  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every prediction has been matched
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_q.size() != 0);
    @(posedge clk);
  endtask

  // Receiver side: random stall bursts, none in the closing stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $realtime, out_tdata);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_tdata[31:0] !== e.data) begin
          $display("%0t: data mismatch, expected %h actual %h",
                   $realtime, e.data, out_tdata[31:0]);
          err_cnt++;
        end
        if (out_tdata[33:32] !== e.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $realtime, e.status, out_tdata[33:32]);
          err_cnt++;
        end
        if (out_tdata[38:34] !== e.count) begin
          $display("%0t: count mismatch, expected %0d actual %0d",
                   $realtime, e.count, out_tdata[38:34]);
          err_cnt++;
        end
        if (out_tdata[39] !== e.empty_res) begin
          $display("%0t: empty_res mismatch, expected %0d actual %0d",
                   $realtime, e.empty_res, out_tdata[39]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    list_cmd_t c;
    int        i;
    int        r;
    int        fill_cnt;

    // Directed table: empty list, fill to capacity, then the full list edges
    add_cmd(OP_GET,    0,  32'h0000_0000, 1, '0,            ST_BADPOS, 0);
    add_cmd(OP_REMOVE, 0,  32'h0000_0000, 1, '0,            ST_BADPOS, 0);
    add_cmd(OP_INSERT, 1,  32'h1234_5678, 1, '0,            ST_BADPOS, 0);
    add_cmd(OP_CLEAR,  0,  32'h0000_0000, 1, '0,            ST_OK,     0);
    add_cmd(OP_INSERT, 0,  32'hFFFF_FFFF, 1, '0,            ST_OK,     1);
    add_cmd(OP_GET,    0,  32'h0000_0000, 1, 32'hFFFF_FFFF, ST_OK,     1);
    add_cmd(OP_INSERT, 0,  32'h0000_0000, 1, '0,            ST_OK,     2);
    add_cmd(OP_INSERT, 2,  32'hA5A5_A5A5, 0, '0,            ST_OK,     0);
    add_cmd(OP_INSERT, 1,  32'h5A5A_5A5A, 0, '0,            ST_OK,     0);
    for (fill_cnt = 4; fill_cnt < LIST_DEPTH; fill_cnt++)
      add_cmd(OP_INSERT, (fill_cnt * 5) % (fill_cnt + 1), 32'hC0DE_0000 + fill_cnt,
              0, '0, ST_OK, 0);
    add_cmd(OP_INSERT, 16, 32'hDEAD_BEEF, 1, '0,            ST_FULL,   16);
    add_cmd(OP_INSERT, 17, 32'hDEAD_BEEF, 1, '0,            ST_BADPOS, 16);
    add_cmd(OP_GET,    16, 32'h0000_0000, 1, '0,            ST_BADPOS, 16);
    add_cmd(OP_REMOVE, 31, 32'h0000_0000, 1, '0,            ST_BADPOS, 16);
    add_cmd(OP_GET,    15, 32'h0000_0000, 0, '0,            ST_OK,     0);
    add_cmd(OP_REMOVE, 15, 32'h0000_0000, 0, '0,            ST_OK,     0);
    add_cmd(OP_CLEAR,  9,  32'h0000_0000, 1, '0,            ST_OK,     0);

    // Hold reset low, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_cmds[i]) begin
      send_cmd(directed_cmds[i]);
      maybe_idle(1'b1);
    end
    drain_results();

    // Random part: mostly legal positions, some noise and clears
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      if (i == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail <= 1'b1;
      c.typed         = 0;
      c.res.data      = '0;
      c.res.status    = ST_OK;
      c.res.count     = '0;
      c.res.empty_res = 1'b0;
      c.elem  = ($urandom_range(0, 15) == 0) ? {ELEM_W{$urandom_range(0, 1) == 1}}
                                            : $urandom();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        c.op  = OP_CLEAR;
        c.pos = POS_W'($urandom_range(0, 31));
      end else if (r < 15) begin
        c.op  = op_t'($urandom_range(0, 3));
        c.pos = POS_W'($urandom_range(0, 31));
        if (c.op == OP_CLEAR) c.op = OP_GET;
      end else begin
        // Lean toward inserts when short, removes when long
        if (model_fill == 0)
          c.op = OP_INSERT;
        else if ($urandom_range(0, 2) == 0)
          c.op = OP_GET;
        else if ($urandom_range(0, LIST_DEPTH) >= model_fill)
          c.op = OP_INSERT;
        else
          c.op = OP_REMOVE;
        if (c.op == OP_INSERT) c.pos = POS_W'($urandom_range(0, model_fill));
        else c.pos = POS_W'($urandom_range(0, model_fill - 1));
      end
      send_cmd(c);
      maybe_idle(i < RANDOM_ITEMS - TAIL_ITEMS);
    end

    // Let the last results out, then give the verdict
    drain_results();
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ilir_pkg.sv
rtl/core/ilir_cell.sv
rtl/core/indexed_list_insert_remove.sv
test/tb_indexed_list_insert_remove.sv
